@@ src/shrs_pkg.sv @@
// ----------------------------------------------------------------------------
// shrs_pkg
// shared types, segment type codes and the class rank function
// ----------------------------------------------------------------------------
package shrs_pkg;

  localparam int unsigned TypeW   = 32;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned RankW   = 3;
  localparam int unsigned OriginW = 4;

  localparam logic [TypeW-1:0] TypeDynamic = 32'h0000_0002;
  localparam logic [TypeW-1:0] TypeInterp  = 32'h0000_0003;
  localparam logic [TypeW-1:0] TypeNote    = 32'h0000_0004;
  localparam logic [TypeW-1:0] TypeSelf    = 32'h0000_0006;
  localparam logic [TypeW-1:0] TypeUnwind  = 32'h6474_e550;
  localparam logic [TypeW-1:0] TypeStack   = 32'h6474_e551;
  localparam logic [TypeW-1:0] TypeRelro   = 32'h6474_e552;

  localparam logic [RankW-1:0] RankSelf    = 3'd0;
  localparam logic [RankW-1:0] RankInterp  = 3'd1;
  localparam logic [RankW-1:0] RankOther   = 3'd2;
  localparam logic [RankW-1:0] RankDynamic = 3'd3;
  localparam logic [RankW-1:0] RankNote    = 3'd4;
  localparam logic [RankW-1:0] RankUnwind  = 3'd5;
  localparam logic [RankW-1:0] RankStack   = 3'd6;
  localparam logic [RankW-1:0] RankRelro   = 3'd7;

  // one stored header
  typedef struct packed {
    logic [RankW-1:0]   rank;
    logic [TypeW-1:0]   seg_type;
    logic [AddrW-1:0]   vaddr;
    logic [OriginW-1:0] origin;
  } entry_t;

  // one classified item between front and back
  typedef struct packed {
    entry_t ent;
    logic   is_final;
  } qitem_t;

  function automatic logic [RankW-1:0] class_rank(input logic [TypeW-1:0] t);
    logic [RankW-1:0] r;
    case (t)
      TypeSelf:    r = RankSelf;
      TypeInterp:  r = RankInterp;
      TypeDynamic: r = RankDynamic;
      TypeNote:    r = RankNote;
      TypeUnwind:  r = RankUnwind;
      TypeStack:   r = RankStack;
      TypeRelro:   r = RankRelro;
      default:     r = RankOther;
    endcase
    return r;
  endfunction

endpackage

@@ src/shrs_if.sv @@
// ----------------------------------------------------------------------------
// shrs_if
// valid/ready channels for header items in and sorted items out
// ----------------------------------------------------------------------------
interface shrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seg_type;
  logic [63:0] seg_vaddr;
  logic        is_final;

  modport source (output valid, seg_type, seg_vaddr, is_final, input ready);
  modport sink   (input valid, seg_type, seg_vaddr, is_final, output ready);
endinterface

interface shrs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  orig_index;
  logic [31:0] out_type;
  logic [63:0] out_vaddr;
  logic        overflowed;
  logic        end_of_run;

  modport source (output valid, orig_index, out_type, out_vaddr, overflowed, end_of_run,
                  input ready);
  modport sink   (input valid, orig_index, out_type, out_vaddr, overflowed, end_of_run,
                  output ready);
endinterface

@@ src/shrs_front.sv @@
// ----------------------------------------------------------------------------
// shrs_front
// accepts header items, ranks the type and tags the arrival position
// ----------------------------------------------------------------------------
module shrs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  shrs_in_if.sink           hdr_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output shrs_pkg::qitem_t  push_data_o
);
  import shrs_pkg::*;

  logic [OriginW-1:0] arrival_q, arrival_d;
  logic               accept;

  assign hdr_i.ready  = push_ready_i;
  assign push_valid_o = hdr_i.valid;
  assign accept       = hdr_i.valid && push_ready_i;

  always_comb begin
    push_data_o.ent.rank     = class_rank(hdr_i.seg_type);
    push_data_o.ent.seg_type = hdr_i.seg_type;
    push_data_o.ent.vaddr    = hdr_i.seg_vaddr;
    push_data_o.ent.origin   = arrival_q;
    push_data_o.is_final     = hdr_i.is_final;
  end

  // arrival position wraps at 4 bits, restarts after the last item of a set
  always_comb begin
    arrival_d = arrival_q;
    if (accept) begin
      arrival_d = hdr_i.is_final ? '0 : arrival_q + OriginW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q <= '0;
    end else begin
      arrival_q <= arrival_d;
    end
  end

endmodule

@@ src/shrs_queue.sv @@
// ----------------------------------------------------------------------------
// shrs_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module shrs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  shrs_pkg::qitem_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output shrs_pkg::qitem_t  pop_data_o
);
  import shrs_pkg::*;

  qitem_t     slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/shrs_back.sv @@
// ----------------------------------------------------------------------------
// shrs_back
// insertion chain of header cells and the sorted drain to the output register
// ----------------------------------------------------------------------------
module shrs_back #(
  parameter int unsigned MAX_HEADERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  shrs_pkg::qitem_t  pop_data_i,
  shrs_out_if.source        res_o
);
  import shrs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_HEADERS + 1);
  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  entry_t                 cell_q [MAX_HEADERS];
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   state_q, state_d;
  logic                   ovf_q, ovf_d;
  logic                   run_ovf_q, run_ovf_d;
  logic                   out_valid_q, out_valid_d;
  entry_t                 out_ent_q;
  logic                   out_ovf_q, out_end_q;

  logic                   pop, full, insert, emit;
  logic [MAX_HEADERS-1:0] lt;

  assign pop_ready_o = (state_q == ST_LOAD);
  assign pop         = pop_valid_i && pop_ready_o;
  assign full        = (cnt_q == CntW'(MAX_HEADERS));
  assign insert      = pop && !full;
  assign emit        = (state_q == ST_DRAIN) && (!out_valid_q || res_o.ready);

  // new item sorts strictly before an occupied cell
  for (genvar g = 0; g < MAX_HEADERS; g++) begin : g_cmp
    assign lt[g] = (CntW'(g) < cnt_q) &&
                   ({pop_data_i.ent.rank, pop_data_i.ent.vaddr} <
                    {cell_q[g].rank, cell_q[g].vaddr});
  end

  for (genvar g = 0; g < MAX_HEADERS; g++) begin : g_cell
    logic take_prev, take_new;
    if (g == 0) begin : g_head
      assign take_prev = 1'b0;
    end else begin : g_body
      assign take_prev = lt[g-1];
    end
    assign take_new = !take_prev && (lt[g] || (CntW'(g) == cnt_q));

    always_ff @(posedge clk_i) begin
      if (insert) begin
        if (take_prev) begin
          cell_q[g] <= cell_q[(g == 0) ? 0 : g-1];
        end else if (take_new) begin
          cell_q[g] <= pop_data_i.ent;
        end
      end else if (emit && (g + 1 < MAX_HEADERS)) begin
        cell_q[g] <= cell_q[(g + 1 < MAX_HEADERS) ? g+1 : g];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    run_ovf_d   = run_ovf_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) out_valid_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (pop) begin
          if (insert) cnt_d = cnt_q + CntW'(1);
          else        ovf_d = 1'b1;
          if (pop_data_i.is_final) begin
            run_ovf_d = ovf_q || full;
            ovf_d     = 1'b0;
            state_d   = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (emit) begin
          out_valid_d = 1'b1;
          cnt_d       = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      run_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      run_ovf_q   <= run_ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ent_q <= cell_q[0];
      out_ovf_q <= run_ovf_q;
      out_end_q <= (cnt_q == CntW'(1));
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.orig_index = out_ent_q.origin;
  assign res_o.out_type   = out_ent_q.seg_type;
  assign res_o.out_vaddr  = out_ent_q.vaddr;
  assign res_o.overflowed = out_ovf_q;
  assign res_o.end_of_run = out_end_q;

endmodule

@@ src/segment_header_rank_sorter.sv @@
// ----------------------------------------------------------------------------
// segment_header_rank_sorter
// collects program header items and emits them sorted by class rank and address
// ----------------------------------------------------------------------------
// usage
//   hdr_i carries one header item per valid/ready handshake: type, address and
//   is_final. res_o carries the sorted items of a set, one per handshake.
//   each header is ranked and tagged with its arrival position (low 4 bits) in
//   the front, passes a two-entry queue, and is placed into a chain of
//   MAX_HEADERS cells by a parallel compare in every cell.
//   order: rank, then address, then arrival (equal keys stay in arrival order).
//   headers past capacity are dropped and set overflowed for that set.
// throughput and drain
//   one header per cycle while a set is loading. the final header starts a
//   drain that shifts one cell per cycle into the output register while the
//   receiver keeps up. the final header passes the queue into the chain, then the
//   first item is registered in the output register. the chain takes no input
//   while draining; the queue absorbs up to two following headers.
// reset and stall
//   reset empties queue, chain and output; no clearing pass is needed. a
//   stalled receiver holds the output register and pauses the drain.
// ----------------------------------------------------------------------------
module segment_header_rank_sorter #(
  parameter int unsigned MAX_HEADERS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  shrs_in_if.sink   hdr_i,
  shrs_out_if.source res_o
);
  import shrs_pkg::*;

  // front to queue
  logic   push_valid, push_ready;
  qitem_t push_data;

  // queue to back
  logic   pop_valid, pop_ready;
  qitem_t pop_data;

  // classify and tag arrivals
  shrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hdr_i        (hdr_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples front from the drain phase
  shrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // insertion chain and sorted output
  shrs_back #(
    .MAX_HEADERS (MAX_HEADERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_o       (res_o)
  );

endmodule

@@ sim/tb_segment_header_rank_sorter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_header_rank_sorter
// self-checking bench for the program header rank sorter
// ----------------------------------------------------------------------------
// header items are pushed through the input channel in sets closed by
// is_final. a shadow insertion store in the bench predicts the sorted items
// of every set, and each item taken from the output channel is compared
// field by field with the oldest prediction. a short directed table comes
// first (single-header sets, field extremes, every class, ties, a full store
// with a dropped final header), then random sets of mixed size with random
// idling on both channels, one long receiver hold-off and one sender pause.
// ----------------------------------------------------------------------------
module tb_segment_header_rank_sorter;
  import shrs_pkg::*;

  localparam int unsigned MaxHeaders  = 16;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned RandomItems = 185;
  localparam int unsigned LongHold    = 120;  // receiver hold-off, in cycles
  localparam int unsigned DrainSlack  = 40;   // quiet cycles after the last item
  localparam int unsigned LimitNs     = 2_000_000;

  // one sorted item as it should leave the block
  typedef struct packed {
    logic [OriginW-1:0] orig;
    logic [TypeW-1:0]   seg_type;
    logic [AddrW-1:0]   vaddr;
    logic               ovf;
    logic               last;
  } sorted_hdr_t;

  // one row of the directed table
  typedef struct {
    logic [TypeW-1:0] seg_type;
    logic [AddrW-1:0] vaddr;
    logic             fin;
    bit               typed;   // single-header set with a hand-written result
    sorted_hdr_t      want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  shrs_in_if  hdr_if ();
  shrs_out_if res_if ();

  segment_header_rank_sorter #(
    .MAX_HEADERS(MaxHeaders)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hdr_i (hdr_if),
    .res_o (res_if)
  );

  // shadow of the sorted store
  logic [RankW-1:0]   shadow_rank   [MaxHeaders];
  logic [TypeW-1:0]   shadow_type   [MaxHeaders];
  logic [AddrW-1:0]   shadow_addr   [MaxHeaders];
  logic [OriginW-1:0] shadow_origin [MaxHeaders];
  int unsigned        shadow_fill;
  bit                 shadow_ovf;
  int unsigned        shadow_arrivals;

  // predicted sorted items, oldest first
  sorted_hdr_t sorted_q [$];
  stim_row_t   dir_rows [$];

  int unsigned errors;
  int unsigned headers_sent;
  int unsigned sets_closed;
  int unsigned overflow_sets;
  int unsigned items_checked;
  bit          hold_req;

  // clock
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin : watchdog
    #(LimitNs);
    $display("%0t: timeout, %0d sorted items still awaited", $time, sorted_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // class rank of a segment type word
  function automatic logic [RankW-1:0] header_class(input logic [TypeW-1:0] t);
    logic [RankW-1:0] r;
    if (t == TypeSelf) r = RankSelf;
    else if (t == TypeInterp) r = RankInterp;
    else if (t == TypeDynamic) r = RankDynamic;
    else if (t == TypeNote) r = RankNote;
    else if (t == TypeUnwind) r = RankUnwind;
    else if (t == TypeStack) r = RankStack;
    else if (t == TypeRelro) r = RankRelro;
    else r = RankOther;
    return r;
  endfunction

  // insert one accepted header into the shadow store; on a final header
  // queue up the whole set in sorted order and start a fresh set
  function automatic void place_header(input logic [TypeW-1:0] t, input logic [AddrW-1:0] a,
                                       input logic fin);
    logic [RankW-1:0]   r;
    logic [OriginW-1:0] org;
    int unsigned        pos;
    sorted_hdr_t        item;
    r   = header_class(t);
    org = shadow_arrivals[OriginW-1:0];
    shadow_arrivals++;
    if (shadow_fill >= MaxHeaders) begin
      // store full: dropped, but the arrival position is used up
      shadow_ovf = 1'b1;
    end else begin
      pos = shadow_fill;
      // strictly-before moves down; equal keys stay behind older ones
      while (pos > 0 && ((r < shadow_rank[pos-1]) ||
                         (r == shadow_rank[pos-1] && a < shadow_addr[pos-1]))) begin
        shadow_rank[pos]   = shadow_rank[pos-1];
        shadow_type[pos]   = shadow_type[pos-1];
        shadow_addr[pos]   = shadow_addr[pos-1];
        shadow_origin[pos] = shadow_origin[pos-1];
        pos--;
      end
      shadow_rank[pos]   = r;
      shadow_type[pos]   = t;
      shadow_addr[pos]   = a;
      shadow_origin[pos] = org;
      shadow_fill++;
    end
    if (fin) begin
      for (int unsigned i = 0; i < shadow_fill; i++) begin
        item.orig     = shadow_origin[i];
        item.seg_type = shadow_type[i];
        item.vaddr    = shadow_addr[i];
        item.ovf      = shadow_ovf;
        item.last     = (i + 1 == shadow_fill);
        sorted_q.push_back(item);
      end
      sets_closed++;
      if (shadow_ovf) overflow_sets++;
      shadow_fill     = 0;
      shadow_ovf      = 1'b0;
      shadow_arrivals = 0;
    end
  endfunction

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // segment types weighted toward the special classes
  function automatic logic [TypeW-1:0] pick_type();
    logic [TypeW-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = TypeSelf;
      1:       t = TypeInterp;
      2:       t = TypeDynamic;
      3:       t = TypeNote;
      4:       t = TypeUnwind;
      5:       t = TypeStack;
      6:       t = TypeRelro;
      7:       t = $urandom();
      8:       t = $urandom_range(0, 7);
      default: t = TypeUnwind + $urandom_range(0, 7);  // neighbors of the os-specific codes
    endcase
    return t;
  endfunction

  // addresses: full random, tiny (to force ties), extremes, low half only
  function automatic logic [AddrW-1:0] pick_addr();
    logic [AddrW-1:0] a;
    case ($urandom_range(0, 4))
      0:       a = {$urandom(), $urandom()};
      1:       a = AddrW'($urandom_range(0, 3));
      2:       a = '0;
      3:       a = '1;
      default: a = {32'h0, $urandom()};
    endcase
    return a;
  endfunction

  function automatic void add_row(input logic [TypeW-1:0] t, input logic [AddrW-1:0] a,
                                  input logic fin, input bit typed, input sorted_hdr_t want);
    stim_row_t row;
    row.seg_type = t;
    row.vaddr    = a;
    row.fin      = fin;
    row.typed    = typed;
    row.want     = want;
    dir_rows.push_back(row);
  endfunction

  // offer one header, wait for the handshake, then predict
  task automatic send_header(input logic [TypeW-1:0] t, input logic [AddrW-1:0] a,
                             input logic fin, input bit burst);
    int unsigned idle;
    idle = burst ? 0 : gap_len();
    if (idle > 0) begin
      hdr_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    hdr_if.valid     <= 1'b1;
    hdr_if.seg_type  <= t;
    hdr_if.seg_vaddr <= a;
    hdr_if.is_final  <= fin;
    @(posedge clk_i);
    while (!hdr_if.ready) @(posedge clk_i);
    place_header(t, a, fin);
    headers_sent++;
  endtask

  // sender holds off until every predicted item has come out
  task automatic wait_drained();
    hdr_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: checks every accepted item, then picks ready for the next cycle
  initial begin : receiver
    int unsigned stall_left;
    int unsigned cycle;
    bit          quiet_rx;
    sorted_hdr_t want;
    stall_left   = 0;
    cycle        = 0;
    quiet_rx     = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (res_if.valid && res_if.ready) begin
        items_checked++;
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected sorted item, expected none, actual index %0h type %0h addr %0h",
                   $time, res_if.orig_index, res_if.out_type, res_if.out_vaddr);
          errors++;
        end else begin
          want = sorted_q.pop_front();
          check_field("orig_index", AddrW'(want.orig), AddrW'(res_if.orig_index));
          check_field("out_type", AddrW'(want.seg_type), AddrW'(res_if.out_type));
          check_field("out_vaddr", want.vaddr, res_if.out_vaddr);
          check_field("overflowed", AddrW'(want.ovf), AddrW'(res_if.overflowed));
          check_field("end_of_run", AddrW'(want.last), AddrW'(res_if.end_of_run));
        end
      end
      // stretches with no stalls at all now and then
      if (cycle % 64 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        // long hold-off so the chain fills and the input backs up
        hold_req   = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && !quiet_rx && $urandom_range(0, 99) < 25) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned rand_target;
    int unsigned set_no;
    int unsigned size;
    int unsigned pick;
    bit          burst;
    sorted_hdr_t typed_want;
    errors           = 0;
    headers_sent     = 0;
    sets_closed      = 0;
    overflow_sets    = 0;
    items_checked    = 0;
    hold_req         = 1'b0;
    shadow_fill      = 0;
    shadow_ovf       = 1'b0;
    shadow_arrivals  = 0;
    rst_ni           <= 1'b0;
    hdr_if.valid     <= 1'b0;
    hdr_if.seg_type  <= '0;
    hdr_if.seg_vaddr <= '0;
    hdr_if.is_final  <= 1'b0;

    // single header right after reset: itself, index 0, last
    add_row(TypeSelf, '0, 1'b1, 1'b1, '{orig: '0, seg_type: TypeSelf, vaddr: '0,
                                        ovf: 1'b0, last: 1'b1});
    // all-ones type and address: plain class, same shape
    add_row('1, '1, 1'b1, 1'b1, '{orig: '0, seg_type: '1, vaddr: '1, ovf: 1'b0, last: 1'b1});
    // seventeen headers, the first eleven in reverse class order, with ties: the
    // final one is dropped because the store is already full
    add_row(TypeRelro,    64'h10, 1'b0, 1'b0, '0);
    add_row(TypeStack,    64'h10, 1'b0, 1'b0, '0);
    add_row(TypeUnwind,   64'h10, 1'b0, 1'b0, '0);
    add_row(TypeNote,     64'h20, 1'b0, 1'b0, '0);
    add_row(TypeNote,     64'h20, 1'b0, 1'b0, '0);  // equal key, arrival order
    add_row(TypeDynamic,  '1,     1'b0, 1'b0, '0);
    add_row(32'h0,        64'h30, 1'b0, 1'b0, '0);
    add_row(32'hffff_ffff, 64'h30, 1'b0, 1'b0, '0); // same class and address
    add_row(TypeInterp,   64'h8,  1'b0, 1'b0, '0);
    add_row(TypeSelf,     64'h40, 1'b0, 1'b0, '0);
    add_row(TypeSelf,     64'h4,  1'b0, 1'b0, '0);
    add_row(32'h1,        '0,     1'b0, 1'b0, '0);
    add_row(TypeRelro,    '0,     1'b0, 1'b0, '0);
    add_row(TypeStack,    '1,     1'b0, 1'b0, '0);
    add_row(TypeUnwind,   64'h5,  1'b0, 1'b0, '0);
    add_row(TypeNote,     64'h1,  1'b0, 1'b0, '0);  // sixteenth, store now full
    add_row(TypeSelf,     '0,     1'b1, 1'b0, '0);  // dropped final header
    // small tie set closing after overflow: flag must be clear again
    add_row(TypeInterp,   64'h7,  1'b0, 1'b0, '0);
    add_row(TypeInterp,   64'h7,  1'b0, 1'b0, '0);
    add_row(TypeInterp,   64'h6,  1'b1, 1'b0, '0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      send_header(dir_rows[i].seg_type, dir_rows[i].vaddr, dir_rows[i].fin, 1'b0);
      if (dir_rows[i].typed) begin
        // the set is this one header: swap the prediction for the written one
        void'(sorted_q.pop_back());
        sorted_q.push_back(dir_rows[i].want);
      end
    end
    wait_drained();

    // random sets, mostly small, some full, a few overflowing
    rand_target = headers_sent + RandomItems;
    set_no      = 0;
    while (headers_sent < rand_target) begin
      burst = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 9);
      if (pick < 6) size = $urandom_range(1, 6);
      else if (pick < 9) size = $urandom_range(7, MaxHeaders);
      else size = $urandom_range(MaxHeaders + 1, MaxHeaders + 4);
      if (set_no == 3) begin
        // full set while the receiver holds off, next set offered back to back
        hold_req = 1'b1;
        size     = MaxHeaders;
        burst    = 1'b1;
      end
      if (set_no == 4) burst = 1'b1;
      if (set_no == 10) wait_drained();
      for (int unsigned k = 0; k < size; k++) begin
        send_header(pick_type(), pick_addr(), (k + 1 == size), burst);
      end
      set_no++;
    end

    // let everything drain, then some quiet cycles for strays
    hdr_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);

    $display("covered %0d headers in %0d sets (%0d with dropped headers)",
             headers_sent, sets_closed, overflow_sets);
    $display("checked %0d sorted items, %0d mismatches", items_checked, errors);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
